@@ src/rhmw_pkg.sv @@
// Shared types and constants of the right-hand maze walker.
`default_nettype none

package rhmw_pkg;

   // Field widths of the request and response payloads.
   localparam int unsigned POS_W   = 6;
   localparam int unsigned SIZE_W  = 7;
   localparam int unsigned HEAD_W  = 2;
   localparam int unsigned STAT_W  = 3;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Request opcodes.
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_STEP    = 2'd2;

   // Response status codes.
   localparam logic [2:0] ST_MOVED   = 3'd0;
   localparam logic [2:0] ST_EXIT    = 3'd1;
   localparam logic [2:0] ST_STUCK   = 3'd2;
   localparam logic [2:0] ST_DONE    = 3'd3;
   localparam logic [2:0] ST_WRITTEN = 3'd4;
   localparam logic [2:0] ST_RESTART = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_HEIGHT     = 3'd0;
   localparam logic [2:0] REG_WIDTH      = 3'd1;
   localparam logic [2:0] REG_START_ROW  = 3'd2;
   localparam logic [2:0] REG_START_COL  = 3'd3;
   localparam logic [2:0] REG_START_HEAD = 3'd4;
   localparam logic [2:0] REG_EXIT_ROW   = 3'd5;
   localparam logic [2:0] REG_EXIT_COL   = 3'd6;

   // Headings.
   localparam logic [1:0] DIR_EAST  = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_WEST  = 2'd2;
   localparam logic [1:0] DIR_NORTH = 2'd3;

   // Row and column offsets for each heading.
   localparam logic signed [1:0] ROW_DELTA [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
   localparam logic signed [1:0] COL_DELTA [4] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};

   // Try order relative to the heading: right, straight, left, reverse.
   localparam logic [1:0] TURN_ORDER [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

   // Reset values of the registers and of the walker.
   localparam logic [6:0] RST_HEIGHT     = 7'd64;
   localparam logic [6:0] RST_WIDTH      = 7'd64;
   localparam logic [5:0] RST_START_ROW  = 6'd2;
   localparam logic [5:0] RST_START_COL  = 6'd0;
   localparam logic [1:0] RST_START_HEAD = DIR_EAST;
   localparam logic [5:0] RST_EXIT_ROW   = 6'd61;
   localparam logic [5:0] RST_EXIT_COL   = 6'd63;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] cell_row;
      logic [5:0] cell_col;
      logic       cell_open;
   } req_type;

   typedef struct packed {
      logic [5:0] walker_row;
      logic [5:0] walker_col;
      logic [1:0] walker_heading;
      logic [2:0] status;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/right_hand_maze_walker.sv @@
// Top level of the right-hand wall-following maze walker.
// A response is registered for each accepted request. Throughput: one request per cycle
// while the skid entry is empty; a restart holds off requests in FSM_LOAD_A and FSM_LOAD_B
// while the three-row window around the new position is read from the grid memory.
// Reset: synchronous; clears walker, registers and the per-row valid bits, so the
// whole grid reads as wall at once with no clearing pass.
`default_nettype none

module right_hand_maze_walker #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  rhmw_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output rhmw_pkg::rsp_type                      rsp_data,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [rhmw_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire  [rhmw_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [rhmw_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int unsigned ROW_W = $clog2(MAX_ROWS);
   localparam int unsigned COL_W = $clog2(MAX_COLS);

   typedef logic [MAX_COLS-1:0] row_bits_type;

   typedef enum logic [1:0] {
      FSM_RUN,
      FSM_LOAD_A,
      FSM_LOAD_B
   } fsm_type;

   // Configuration registers.
   logic [6:0] height_ff, width_ff;
   logic [5:0] start_row_ff, start_col_ff, exit_row_ff, exit_col_ff;
   logic [1:0] start_head_ff;

   // Walker state, neighborhood window and response path.
   fsm_type           state_ff, state_in;
   logic [5:0]        pos_row_ff, pos_row_in, pos_col_ff, pos_col_in;
   logic [1:0]        heading_ff, heading_in;
   logic              finished_ff, finished_in;
   row_bits_type      win_ff [3];
   row_bits_type      win_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   rhmw_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              skid_vld_ff, skid_vld_in;
   rhmw_pkg::rsp_type skid_data_ff, skid_data_in;

   // Grid memory, row valid bits and registered read ports.
   row_bits_type      grid_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] row_vld_ff;
   row_bits_type      rd_a_raw_ff, rd_b_raw_ff;
   logic              rd_a_ok_ff, rd_a_ok_in, rd_b_ok_ff, rd_b_ok_in;
   logic              rd_a_hit_ff, rd_a_hit_in, rd_b_hit_ff, rd_b_hit_in;
   logic [COL_W-1:0]  wr_col_ff;
   logic              wr_bit_ff;

   // Combinational helpers.
   logic              req_take, rsp_take, csr_wr, at_exit, found;
   logic              wr_en;
   logic [8:0]        wr_row9, wr_col9, rd_a9, rd_b9;
   logic [ROW_W-1:0]  wr_row_idx, rd_a_idx, rd_b_idx;
   logic [COL_W-1:0]  wr_col_idx;
   row_bits_type      wr_fresh, eff_a, eff_b;
   logic [8:0]        nbr_row [4];
   logic [8:0]        nbr_col [4];
   logic [3:0]        dir_open;
   logic [1:0]        sel_dir;
   rhmw_pkg::rsp_type res;

   // Handshake ports.
   assign req_stall  = skid_vld_ff || (state_ff != FSM_RUN);
   assign req_take   = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff     <= rhmw_pkg::RST_HEIGHT;
         width_ff      <= rhmw_pkg::RST_WIDTH;
         start_row_ff  <= rhmw_pkg::RST_START_ROW;
         start_col_ff  <= rhmw_pkg::RST_START_COL;
         start_head_ff <= rhmw_pkg::RST_START_HEAD;
         exit_row_ff   <= rhmw_pkg::RST_EXIT_ROW;
         exit_col_ff   <= rhmw_pkg::RST_EXIT_COL;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            rhmw_pkg::REG_HEIGHT:     height_ff     <= csr_pwdata[6:0];
            rhmw_pkg::REG_WIDTH:      width_ff      <= csr_pwdata[6:0];
            rhmw_pkg::REG_START_ROW:  start_row_ff  <= csr_pwdata[5:0];
            rhmw_pkg::REG_START_COL:  start_col_ff  <= csr_pwdata[5:0];
            rhmw_pkg::REG_START_HEAD: start_head_ff <= csr_pwdata[1:0];
            rhmw_pkg::REG_EXIT_ROW:   exit_row_ff   <= csr_pwdata[5:0];
            rhmw_pkg::REG_EXIT_COL:   exit_col_ff   <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[4:2])
         rhmw_pkg::REG_HEIGHT:     csr_prdata = 32'(height_ff);
         rhmw_pkg::REG_WIDTH:      csr_prdata = 32'(width_ff);
         rhmw_pkg::REG_START_ROW:  csr_prdata = 32'(start_row_ff);
         rhmw_pkg::REG_START_COL:  csr_prdata = 32'(start_col_ff);
         rhmw_pkg::REG_START_HEAD: csr_prdata = 32'(start_head_ff);
         rhmw_pkg::REG_EXIT_ROW:   csr_prdata = 32'(exit_row_ff);
         rhmw_pkg::REG_EXIT_COL:   csr_prdata = 32'(exit_col_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // Cell write decode; writes outside the store are dropped.
   always_comb begin
      wr_row9    = 9'(req_data.cell_row);
      wr_col9    = 9'(req_data.cell_col);
      wr_row_idx = wr_row9[ROW_W-1:0];
      wr_col_idx = wr_col9[COL_W-1:0];
      wr_en      = req_take && (req_data.opcode == rhmw_pkg::OP_WRITE)
                   && (wr_row9 < 9'(MAX_ROWS)) && (wr_col9 < 9'(MAX_COLS));
      wr_fresh   = '0;
      wr_fresh[wr_col_idx] = req_data.cell_open;
   end

   // Read data with never-written rows forced to wall and a same-cycle write merged in.
   always_comb begin
      eff_a = rd_a_ok_ff ? rd_a_raw_ff : '0;
      eff_b = rd_b_ok_ff ? rd_b_raw_ff : '0;
      if (rd_a_hit_ff) begin
         eff_a[wr_col_ff] = wr_bit_ff;
      end
      if (rd_b_hit_ff) begin
         eff_b[wr_col_ff] = wr_bit_ff;
      end
   end

   // The four neighbors of the walker, tested against the rows and columns in use.
   always_comb begin
      row_bits_type wrow;
      for (int d = 0; d < 4; d++) begin
         nbr_row[d] = 9'(pos_row_ff)
                      + {{7{rhmw_pkg::ROW_DELTA[d][1]}}, rhmw_pkg::ROW_DELTA[d]};
         nbr_col[d] = 9'(pos_col_ff)
                      + {{7{rhmw_pkg::COL_DELTA[d][1]}}, rhmw_pkg::COL_DELTA[d]};
         if (2'(d) == rhmw_pkg::DIR_SOUTH) begin
            wrow = win_ff[2];
         end else if (2'(d) == rhmw_pkg::DIR_NORTH) begin
            wrow = win_ff[0];
         end else begin
            wrow = win_ff[1];
         end
         dir_open[d] = !nbr_row[d][8] && (nbr_row[d] < 9'(height_ff))
                       && (nbr_row[d] < 9'(MAX_ROWS))
                       && !nbr_col[d][8] && (nbr_col[d] < 9'(width_ff))
                       && (nbr_col[d] < 9'(MAX_COLS))
                       && wrow[nbr_col[d][COL_W-1:0]];
      end
   end

   // Right-hand choice: first open cell in the order right, straight, left, reverse.
   always_comb begin
      logic [1:0] d;
      found   = 1'b0;
      sel_dir = heading_ff;
      for (int k = 0; k < 4; k++) begin
         d = heading_ff + rhmw_pkg::TURN_ORDER[k];
         if (!found && dir_open[d]) begin
            found   = 1'b1;
            sel_dir = d;
         end
      end
   end

   assign at_exit = (pos_row_ff == exit_row_ff) && (pos_col_ff == exit_col_ff);

   // Next walker state, window contents and the response for an accepted request.
   always_comb begin
      state_in    = state_ff;
      pos_row_in  = pos_row_ff;
      pos_col_in  = pos_col_ff;
      heading_in  = heading_ff;
      finished_in = finished_ff;
      win_in      = win_ff;
      res.status  = rhmw_pkg::ST_DONE;
      unique case (state_ff)
         FSM_LOAD_A: begin
            win_in[0] = eff_a;
            win_in[1] = eff_b;
            state_in  = FSM_LOAD_B;
         end
         FSM_LOAD_B: begin
            win_in[2] = eff_a;
            state_in  = FSM_RUN;
         end
         FSM_RUN: begin
            if (req_take) begin
               unique case (req_data.opcode)
                  rhmw_pkg::OP_WRITE: begin
                     res.status = rhmw_pkg::ST_WRITTEN;
                     for (int k = 0; k < 3; k++) begin
                        if (wr_en && (wr_row9 == 9'(pos_row_ff) + 9'(k) - 9'd1)) begin
                           win_in[k][wr_col_idx] = req_data.cell_open;
                        end
                     end
                  end
                  rhmw_pkg::OP_RESTART: begin
                     pos_row_in  = start_row_ff;
                     pos_col_in  = start_col_ff;
                     heading_in  = start_head_ff;
                     finished_in = 1'b0;
                     state_in    = FSM_LOAD_A;
                     res.status  = rhmw_pkg::ST_RESTART;
                  end
                  rhmw_pkg::OP_STEP: begin
                     if (finished_ff || at_exit) begin
                        finished_in = 1'b1;
                        res.status  = rhmw_pkg::ST_DONE;
                     end else if (found) begin
                        pos_row_in = nbr_row[sel_dir][5:0];
                        pos_col_in = nbr_col[sel_dir][5:0];
                        heading_in = sel_dir;
                        if ((nbr_row[sel_dir][5:0] == exit_row_ff)
                            && (nbr_col[sel_dir][5:0] == exit_col_ff)) begin
                           finished_in = 1'b1;
                           res.status  = rhmw_pkg::ST_EXIT;
                        end else begin
                           res.status  = rhmw_pkg::ST_MOVED;
                        end
                        // Slide the window one row; a row that wraps reloads it.
                        if (sel_dir == rhmw_pkg::DIR_NORTH) begin
                           win_in[0] = eff_a;
                           win_in[1] = win_ff[0];
                           win_in[2] = win_ff[1];
                        end else if (sel_dir == rhmw_pkg::DIR_SOUTH) begin
                           if (pos_row_ff == 6'd63) begin
                              state_in = FSM_LOAD_A;
                           end else begin
                              win_in[0] = win_ff[1];
                              win_in[1] = win_ff[2];
                              win_in[2] = eff_b;
                           end
                        end
                     end else begin
                        res.status = rhmw_pkg::ST_STUCK;
                     end
                  end
                  default: res.status = rhmw_pkg::ST_DONE;
               endcase
            end
         end
         default: state_in = FSM_RUN;
      endcase
      res.walker_row     = pos_row_in;
      res.walker_col     = pos_col_in;
      res.walker_heading = heading_in;
   end

   // Read addresses follow the next position: window rows while loading, else the
   // rows two above and two below so that a vertical move can slide the window.
   always_comb begin
      unique case (state_in)
         FSM_LOAD_A: begin
            rd_a9 = 9'(pos_row_in) - 9'd1;
            rd_b9 = 9'(pos_row_in);
         end
         FSM_LOAD_B: begin
            rd_a9 = 9'(pos_row_in) + 9'd1;
            rd_b9 = 9'(pos_row_in) + 9'd2;
         end
         default: begin
            rd_a9 = 9'(pos_row_in) - 9'd2;
            rd_b9 = 9'(pos_row_in) + 9'd2;
         end
      endcase
      rd_a_idx    = rd_a9[ROW_W-1:0];
      rd_b_idx    = rd_b9[ROW_W-1:0];
      rd_a_ok_in  = !rd_a9[8] && (rd_a9 < 9'(MAX_ROWS)) && row_vld_ff[rd_a_idx];
      rd_b_ok_in  = !rd_b9[8] && (rd_b9 < 9'(MAX_ROWS)) && row_vld_ff[rd_b_idx];
      rd_a_hit_in = wr_en && (wr_row9 == rd_a9);
      rd_b_hit_in = wr_en && (wr_row9 == rd_b9);
   end

   // Grid memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (row_vld_ff[wr_row_idx]) begin
            grid_mem[wr_row_idx][wr_col_idx] <= req_data.cell_open;
         end else begin
            grid_mem[wr_row_idx] <= wr_fresh;
         end
      end
      rd_a_raw_ff <= grid_mem[rd_a_idx];
      rd_b_raw_ff <= grid_mem[rd_b_idx];
   end

   // Row valid bits and read-port qualifiers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff  <= '0;
         rd_a_ok_ff  <= 1'b0;
         rd_b_ok_ff  <= 1'b0;
         rd_a_hit_ff <= 1'b0;
         rd_b_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_row_idx] <= 1'b1;
         end
         rd_a_ok_ff  <= rd_a_ok_in;
         rd_b_ok_ff  <= rd_b_ok_in;
         rd_a_hit_ff <= rd_a_hit_in;
         rd_b_hit_ff <= rd_b_hit_in;
      end
      wr_col_ff <= wr_col_idx;
      wr_bit_ff <= req_data.cell_open;
   end

   // Response register with a skid entry behind it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (rsp_take) begin
            rsp_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (req_take) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_in  = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in = res;
            skid_vld_in  = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Walker state machine, window and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_RUN;
         pos_row_ff   <= rhmw_pkg::RST_START_ROW;
         pos_col_ff   <= rhmw_pkg::RST_START_COL;
         heading_ff   <= rhmw_pkg::RST_START_HEAD;
         finished_ff  <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            win_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         heading_ff   <= heading_in;
         finished_ff  <= finished_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_vld_ff  <= skid_vld_in;
         rsp_data_ff  <= rsp_data_in;
         skid_data_ff <= skid_data_in;
      end
   end

endmodule

`default_nettype wire

@@ src/rhmw_checker.sv @@
// Port-level checks of the maze walker and their bind to the top level.
`default_nettype none

module rhmw_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_stall,
   input rhmw_pkg::req_type               req_data,
   input wire                             rsp_valid,
   input wire                             rsp_stall,
   input rhmw_pkg::rsp_type               rsp_data
);

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Every accepted request leaves a response waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // A restart holds off the next request while the window reloads.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == rhmw_pkg::OP_RESTART) |=> req_stall)
      else $error("request accepted during window reload");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= rhmw_pkg::ST_RESTART)
      else $error("undefined response status");

endmodule

bind right_hand_maze_walker rhmw_checker u_rhmw_checker (.*);

`default_nettype wire

@@ sim/maze_walk_tb_pkg.sv @@
// Scoreboard for the maze walker: a walker predictor and the queue of expected responses.
package maze_walk_tb_pkg;

   import rhmw_pkg::*;

   class walker_scoreboard;

      localparam int GRID_DIM = 64;

      // Predicted grid, registers and walker state.
      bit          open_cell [GRID_DIM][GRID_DIM];
      logic [6:0]  maze_height;
      logic [6:0]  maze_width;
      logic [5:0]  start_row;
      logic [5:0]  start_col;
      logic [1:0]  start_heading;
      logic [5:0]  exit_row;
      logic [5:0]  exit_col;
      logic [5:0]  pos_row;
      logic [5:0]  pos_col;
      logic [1:0]  heading;
      bit          finished;

      rsp_type     expected_walks [$];
      int unsigned error_count;

      function new();
         foreach (open_cell[r, c]) open_cell[r][c] = 1'b0;
         maze_height   = RST_HEIGHT;
         maze_width    = RST_WIDTH;
         start_row     = RST_START_ROW;
         start_col     = RST_START_COL;
         start_heading = RST_START_HEAD;
         exit_row      = RST_EXIT_ROW;
         exit_col      = RST_EXIT_COL;
         pos_row       = RST_START_ROW;
         pos_col       = RST_START_COL;
         heading       = RST_START_HEAD;
         finished      = 1'b0;
         error_count   = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_HEIGHT:     maze_height   = value[6:0];
            REG_WIDTH:      maze_width    = value[6:0];
            REG_START_ROW:  start_row     = value[5:0];
            REG_START_COL:  start_col     = value[5:0];
            REG_START_HEAD: start_heading = value[1:0];
            REG_EXIT_ROW:   exit_row      = value[5:0];
            REG_EXIT_COL:   exit_col      = value[5:0];
            default: ;
         endcase
      endfunction

      // Cells beyond the rows and columns in use read as walls.
      function bit is_open(int r, int c);
         int rows;
         int cols;
         rows = (maze_height > GRID_DIM) ? GRID_DIM : int'(maze_height);
         cols = (maze_width > GRID_DIM) ? GRID_DIM : int'(maze_width);
         if (r < 0 || c < 0 || r >= rows || c >= cols) return 1'b0;
         return open_cell[r][c];
      endfunction

      // One step by the right-hand rule: right, straight, left, then back.
      function logic [2:0] step_walker();
         logic [1:0] dir;
         int         r;
         int         c;
         int         k;
         if (finished || (pos_row == exit_row && pos_col == exit_col)) begin
            finished = 1'b1;
            return ST_DONE;
         end
         for (k = 0; k < 4; k++) begin
            case (k)
               0:       dir = heading + 2'd1;
               1:       dir = heading;
               2:       dir = heading + 2'd3;
               default: dir = heading + 2'd2;
            endcase
            r = int'(pos_row) + ((dir == DIR_SOUTH) ? 1 : (dir == DIR_NORTH) ? -1 : 0);
            c = int'(pos_col) + ((dir == DIR_EAST) ? 1 : (dir == DIR_WEST) ? -1 : 0);
            if (is_open(r, c)) begin
               pos_row = r[5:0];
               pos_col = c[5:0];
               heading = dir;
               if (pos_row == exit_row && pos_col == exit_col) begin
                  finished = 1'b1;
                  return ST_EXIT;
               end
               return ST_MOVED;
            end
         end
         return ST_STUCK;
      endfunction

      // Applies one request to the predicted state and returns the response it causes.
      function rsp_type walk_one(req_type r);
         rsp_type    result;
         logic [2:0] st;
         case (r.opcode)
            OP_WRITE: begin
               open_cell[r.cell_row][r.cell_col] = r.cell_open;
               st = ST_WRITTEN;
            end
            OP_RESTART: begin
               pos_row  = start_row;
               pos_col  = start_col;
               heading  = start_heading;
               finished = 1'b0;
               st       = ST_RESTART;
            end
            OP_STEP: st = step_walker();
            default: st = ST_DONE;
         endcase
         result.walker_row     = pos_row;
         result.walker_col     = pos_col;
         result.walker_heading = heading;
         result.status         = st;
         return result;
      endfunction

      function void note_request(req_type r);
         expected_walks.push_back(walk_one(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_walks.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            error_count++;
            return;
         end
         want = expected_walks.pop_front();
         if (got.walker_row !== want.walker_row) begin
            $error("walker_row expected %0d actual %0d", want.walker_row, got.walker_row);
            error_count++;
         end
         if (got.walker_col !== want.walker_col) begin
            $error("walker_col expected %0d actual %0d", want.walker_col, got.walker_col);
            error_count++;
         end
         if (got.walker_heading !== want.walker_heading) begin
            $error("walker_heading expected %0d actual %0d",
                   want.walker_heading, got.walker_heading);
            error_count++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            error_count++;
         end
      endfunction

      function int unsigned waiting();
         return expected_walks.size();
      endfunction

   endclass

endpackage

@@ sim/tb_top.sv @@
// Top-level testbench of the right-hand maze walker: stimulus, handshakes and checking.
module tb_top;

   import rhmw_pkg::*;
   import maze_walk_tb_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1250;
   localparam int unsigned QUIET_LIMIT  = 1000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   walker_scoreboard sb = new();

   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;
   bit          calm         = 1'b0;

   right_hand_maze_walker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // The response side stalls at random except during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 12);
   end

   // Check every accepted response and count cycles in which nothing moves.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Watchdog on a hung handshake.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Presents one request, with a random gap in front, and records it once accepted.
   task automatic send_request(input req_type r);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      items_sent++;
   endtask

   task automatic send_op(input logic [1:0] op, input logic [5:0] row, input logic [5:0] col,
                          input logic open);
      req_type r;
      r.opcode    = op;
      r.cell_row  = row;
      r.cell_col  = col;
      r.cell_open = open;
      send_request(r);
   endtask

   // Random row and column content goes with steps and restarts too.
   task automatic send_walk_op(input logic [1:0] op);
      send_op(op, 6'($urandom_range(63)), 6'($urandom_range(63)), 1'($urandom_range(1)));
   endtask

   // Waits for every outstanding response, then for the restart window read to finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] h, input logic [6:0] w,
                            input logic [5:0] sr, input logic [5:0] sc, input logic [1:0] sh,
                            input logic [5:0] er, input logic [5:0] ec);
      settle();
      csr_write(REG_HEIGHT, 32'(h));
      csr_write(REG_WIDTH, 32'(w));
      csr_write(REG_START_ROW, 32'(sr));
      csr_write(REG_START_COL, 32'(sc));
      csr_write(REG_START_HEAD, 32'(sh));
      csr_write(REG_EXIT_ROW, 32'(er));
      csr_write(REG_EXIT_COL, 32'(ec));
   endtask

   // Grid sizes: mostly small, with the extremes and an occasional out-of-range size.
   function automatic logic [6:0] pick_size();
      case ($urandom_range(19))
         0, 1:    return 7'd64;
         2, 3:    return 7'd3;
         4:       return 7'($urandom_range(65, 127));
         5:       return 7'($urandom_range(0, 2));
         default: return 7'($urandom_range(4, 9));
      endcase
   endfunction

   function automatic logic [5:0] pick_coord(input int used);
      if (used == 0 || $urandom_range(7) == 0) return 6'($urandom_range(63));
      return 6'($urandom_range(used - 1));
   endfunction

   // One random phase: a new setting, a fresh maze, then a walk through it.
   task automatic run_phase();
      logic [6:0] h;
      logic [6:0] w;
      logic [5:0] sr;
      logic [5:0] sc;
      int         rows;
      int         cols;
      int         cr;
      int         cc;
      int         dir;
      int         roll;
      int         n;
      h    = pick_size();
      w    = pick_size();
      rows = (h > 64) ? 64 : int'(h);
      cols = (w > 64) ? 64 : int'(w);
      sr   = pick_coord(rows);
      sc   = pick_coord(cols);
      configure(h, w, sr, sc, 2'($urandom_range(3)), pick_coord(rows), pick_coord(cols));

      // Small grids are filled cell by cell; large ones get a random corridor.
      if (rows * cols <= 100) begin
         for (cr = 0; cr < rows; cr++)
            for (cc = 0; cc < cols; cc++)
               send_op(OP_WRITE, 6'(cr), 6'(cc), $urandom_range(99) < 65);
      end else begin
         cr = (int'(sr) < rows) ? int'(sr) : 0;
         cc = (int'(sc) < cols) ? int'(sc) : 0;
         repeat (80) begin
            send_op(OP_WRITE, 6'(cr), 6'(cc), 1'b1);
            dir = $urandom_range(3);
            if (dir == 0 && cc + 1 < cols) cc++;
            if (dir == 1 && cr + 1 < rows) cr++;
            if (dir == 2 && cc > 0) cc--;
            if (dir == 3 && cr > 0) cr--;
         end
      end

      send_walk_op(OP_RESTART);
      n = $urandom_range(20, 50);
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 80)
            send_walk_op(OP_STEP);
         else if (roll < 94)
            send_op(OP_WRITE, pick_coord(rows), pick_coord(cols), 1'($urandom_range(1)));
         else
            send_walk_op(OP_RESTART);
      end
   endtask

   initial begin
      int unsigned random_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: an all-wall grid, the field extremes, an undefined opcode and a short walk.
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);
      send_op(OP_WRITE, 6'd2, 6'd1, 1'b1);
      send_op(OP_STEP, 6'd63, 6'd63, 1'b1);
      send_op(2'd3, 6'd0, 6'd0, 1'b0);
      send_op(OP_WRITE, 6'd0, 6'd0, 1'b1);
      send_op(OP_WRITE, 6'd63, 6'd63, 1'b1);
      send_op(OP_WRITE, 6'd0, 6'd63, 1'b0);
      send_op(OP_WRITE, 6'd63, 6'd0, 1'b1);
      send_op(OP_RESTART, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);

      // Reaching the exit, then a step while finished.
      configure(7'd64, 7'd64, 6'd2, 6'd0, DIR_EAST, 6'd2, 6'd1);
      send_op(OP_RESTART, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);

      // A restart onto the exit cell itself.
      configure(7'd64, 7'd64, 6'd2, 6'd0, DIR_EAST, 6'd2, 6'd0);
      send_op(OP_RESTART, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);

      // In the top left corner only the cell behind is open; the rest is wall or off-grid.
      configure(7'd3, 7'd3, 6'd0, 6'd0, DIR_NORTH, 6'd5, 6'd5);
      send_op(OP_WRITE, 6'd1, 6'd0, 1'b1);
      send_op(OP_RESTART, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);

      // Height above the maximum and a width of zero.
      configure(7'd127, 7'd0, 6'd1, 6'd1, DIR_SOUTH, 6'd63, 6'd63);
      send_op(OP_RESTART, 6'd0, 6'd0, 1'b0);
      send_op(OP_STEP, 6'd0, 6'd0, 1'b0);

      // Random phases, with a stretch of no idling on either side.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         calm = (items_sent - random_start >= 500) && (items_sent - random_start < 750);
         run_phase();
      end
      calm = 1'b0;

      settle();
      if (sb.waiting() != 0) begin
         $error("%0d responses never arrived", sb.waiting());
         sb.error_count++;
      end
      if (sb.error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
